[design/fmo_pkg.sv]
// Shared types, widths and elaboration-time sine table math for the FM oscillator.
package fmo_pkg;

   localparam int PHASE_W  = 32;
   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = 15;
   localparam int RATIO_W  = 24;
   localparam int DEPTH_W  = 31;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Register index, taken from byte address bit 2
   typedef enum logic {
      CSR_MOD_RATIO = 1'b0,
      CSR_MOD_DEPTH = 1'b1
   } csr_index_type;

   // One queued request: the two phases that the back end looks up.
   typedef struct packed {
      logic [PHASE_W-1:0] carrier_phase;
      logic [PHASE_W-1:0] modulator_phase;
   } fmo_item_type;

   // Series math in Q60; terms that reach zero stay zero, so a fixed count suffices.
   localparam int SERIES_TERMS = 16;
   localparam logic [63:0] Q_ONE = 64'h1000_0000_0000_0000;
   localparam logic [63:0] ATAN_DIV [SERIES_TERMS] = '{
      64'd1,  64'd3,  64'd5,  64'd7,  64'd9,  64'd11, 64'd13, 64'd15,
      64'd17, 64'd19, 64'd21, 64'd23, 64'd25, 64'd27, 64'd29, 64'd31
   };
   localparam logic [63:0] SIN_DIV [SERIES_TERMS] = '{
      64'd1,   64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
      64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
   };

   function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // atan(1/5) when wide_arg is low, atan(1/239) when high
   function automatic logic [63:0] q_atan_inv(input logic wide_arg);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] d;
      term = wide_arg ? Q_ONE / 239 : Q_ONE / 5;
      sum  = term;
      for (int n = 1; n < SERIES_TERMS; n++) begin
         term = wide_arg ? term / 57121 : term / 25;
         d = term / ATAN_DIV[n];
         if (n[0]) sum = sum - d;
         else sum = sum + d;
      end
      return sum;
   endfunction

   function automatic logic [63:0] q_pi();
      return (q_atan_inv(1'b0) << 4) - (q_atan_inv(1'b1) << 2);
   endfunction

   function automatic logic [63:0] q_sin(input logic [63:0] x);
      logic [63:0] sum;
      logic [63:0] term;
      sum  = x;
      term = x;
      for (int n = 1; n < SERIES_TERMS; n++) begin
         term = q_mul(q_mul(term, x), x) / SIN_DIV[n];
         if (n[0]) sum = sum - term;
         else sum = sum + term;
      end
      return sum;
   endfunction

   // Quarter-wave entry k of a table with 2^addr_bits entries per full sine period.
   function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] pi_q,
                                                     input int addr_bits, input int k);
      logic [63:0] step_hi;
      logic [63:0] step_lo;
      logic [63:0] theta;
      logic [63:0] kk;
      logic [63:0] scaled;
      int quarter;
      quarter = 1 << (addr_bits - 2);
      kk      = 64'(k);
      step_hi = pi_q >> (addr_bits - 1);
      step_lo = pi_q & ((64'd1 << (addr_bits - 1)) - 64'd1);
      theta   = step_hi * kk + ((step_lo * kk) >> (addr_bits - 1));
      scaled  = q_mul(q_sin(theta), 64'd32767);
      if (k == 0) return '0;
      if (k == quarter) return MAG_W'(32767);
      return scaled[MAG_W-1:0];
   endfunction

endpackage

[design/fmo_front.sv]
// Front end: accepts phase steps, runs both phase accumulators, feeds the queue.
module fmo_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fmo_pkg::PHASE_W-1:0]   req_phase_step,
   input  logic [fmo_pkg::RATIO_W-1:0]   mod_ratio,
   input  logic                          q_full,
   output logic                          push,
   output fmo_pkg::fmo_item_type         push_item
);
   import fmo_pkg::*;

   logic                     accept;
   logic                     s1_valid_ff, s1_valid_in;
   logic [PHASE_W-1:0]       s1_cphase_ff;
   logic [PHASE_W-1:0]       s1_inc_ff;
   logic [PHASE_W-1:0]       carrier_acc_ff, carrier_acc_in;
   logic [PHASE_W-1:0]       mod_acc_ff, mod_acc_in;
   logic [PHASE_W+RATIO_W-1:0] step_prod;

   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = s1_valid_ff && !q_full;

   assign step_prod = {{RATIO_W{1'b0}}, req_phase_step} * {{PHASE_W{1'b0}}, mod_ratio};

   always_comb begin
      s1_valid_in    = accept || (s1_valid_ff && !push);
      carrier_acc_in = accept ? carrier_acc_ff + req_phase_step : carrier_acc_ff;
      // the modulator phase of a request is the sum of all earlier increments
      mod_acc_in     = push ? mod_acc_ff + s1_inc_ff : mod_acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         carrier_acc_ff <= '0;
         mod_acc_ff     <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         carrier_acc_ff <= carrier_acc_in;
         mod_acc_ff     <= mod_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cphase_ff <= carrier_acc_ff;
         s1_inc_ff    <= step_prod[PHASE_W+15:16];
      end
   end

   assign push_item.carrier_phase   = s1_cphase_ff;
   assign push_item.modulator_phase = mod_acc_ff;

endmodule

[design/fmo_queue.sv]
// Short request queue between the front and back ends.
module fmo_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fmo_pkg::fmo_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output fmo_pkg::fmo_item_type head_item
);
   import fmo_pkg::*;

   fmo_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != QCNT_W'(QUEUE_DEPTH))
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count did not follow a lone push");
`endif

endmodule

[design/fmo_rom.sv]
// Dual-port quarter-wave sine ROM with registered reads and quadrant folding.
module fmo_rom #(
   parameter int ADDR_BITS = 12
) (
   input  logic                       clock,
   input  logic                       rd_en_a,
   input  logic [ADDR_BITS-1:0]       rd_addr_a,
   output logic [fmo_pkg::MAG_W-1:0]  rd_mag_a,
   output logic                       rd_neg_a,
   input  logic                       rd_en_b,
   input  logic [ADDR_BITS-1:0]       rd_addr_b,
   output logic [fmo_pkg::MAG_W-1:0]  rd_mag_b,
   output logic                       rd_neg_b
);
   import fmo_pkg::*;

   localparam int QUARTER  = 1 << (ADDR_BITS - 2);
   localparam int IDX_BITS = ADDR_BITS - 1;
   localparam logic [63:0] PI_Q = q_pi();

   logic [MAG_W-1:0] quarter_rom [QUARTER+1];
   logic [MAG_W-1:0] mag_a_ff, mag_b_ff;
   logic             neg_a_ff, neg_b_ff;

   for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
      localparam logic [MAG_W-1:0] ENTRY = quarter_sine(PI_Q, ADDR_BITS, k);
      assign quarter_rom[k] = ENTRY;
   end

   // mirror the second and fourth quadrants onto the first
   function automatic logic [IDX_BITS-1:0] fold_index(input logic [ADDR_BITS-1:0] addr);
      logic [IDX_BITS-1:0] low;
      low = {1'b0, addr[ADDR_BITS-3:0]};
      if (addr[ADDR_BITS-2]) return IDX_BITS'(QUARTER) - low;
      return low;
   endfunction

   always_ff @(posedge clock) begin
      if (rd_en_a) begin
         mag_a_ff <= quarter_rom[fold_index(rd_addr_a)];
         neg_a_ff <= rd_addr_a[ADDR_BITS-1];
      end
      if (rd_en_b) begin
         mag_b_ff <= quarter_rom[fold_index(rd_addr_b)];
         neg_b_ff <= rd_addr_b[ADDR_BITS-1];
      end
   end

   assign rd_mag_a = mag_a_ff;
   assign rd_neg_a = neg_a_ff;
   assign rd_mag_b = mag_b_ff;
   assign rd_neg_b = neg_b_ff;

endmodule

[design/fmo_back.sv]
// Back end: modulator lookup, depth scaling, carrier lookup and output register.
module fmo_back #(
   parameter int ADDR_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  fmo_pkg::fmo_item_type               head_item,
   output logic                                pop,
   input  logic [fmo_pkg::DEPTH_W-1:0]         mod_depth,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fmo_pkg::SAMPLE_W-1:0] rsp_sample
);
   import fmo_pkg::*;

   localparam int PROD_W = DEPTH_W + MAG_W;

   logic                 adv;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic [PHASE_W-1:0]   cph1_ff, cph2_ff, cph3_ff, cph3_in;
   logic [PROD_W-1:0]    prod2_ff;
   logic                 neg2_ff;
   logic [PHASE_W-1:0]   offset;
   logic [MAG_W-1:0]     mag_a, mag_b;
   logic                 neg_a, neg_b;
   logic [SAMPLE_W-1:0]  mag_ext;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   // the whole pipe advances whenever the output register can take a result
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   fmo_rom #(.ADDR_BITS(ADDR_BITS)) u_rom (
      .clock     (clock),
      .rd_en_a   (adv),
      .rd_addr_a (head_item.modulator_phase[PHASE_W-1 -: ADDR_BITS]),
      .rd_mag_a  (mag_a),
      .rd_neg_a  (neg_a),
      .rd_en_b   (adv),
      .rd_addr_b (cph3_ff[PHASE_W-1 -: ADDR_BITS]),
      .rd_mag_b  (mag_b),
      .rd_neg_b  (neg_b)
   );

   // truncation toward zero: scale the magnitude, then apply the sign as add or subtract
   assign offset  = {1'b0, prod2_ff[PROD_W-1:MAG_W]};
   assign cph3_in = neg2_ff ? cph2_ff - offset : cph2_ff + offset;
   assign mag_ext = {1'b0, mag_b};
   assign rsp_sample_in = neg_b ? $signed(SAMPLE_W'(0) - mag_ext) : $signed(mag_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= head_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cph1_ff       <= head_item.carrier_phase;
         prod2_ff      <= {{MAG_W{1'b0}}, mod_depth} * {{DEPTH_W{1'b0}}, mag_a};
         neg2_ff       <= neg_a;
         cph2_ff       <= cph1_ff;
         cph3_ff       <= cph3_in;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

`ifndef SYNTHESIS
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff != 16'sh8000)
      else $error("sample outside the table range");
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (adv && v4_ff) |=> rsp_valid_ff)
      else $error("result lost before the output register");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("queue drained while the output is stalled");
`endif

endmodule

[design/two_operator_fm_oscillator.sv]
// Top level of the two-operator FM oscillator: CSR block and front/queue/back wiring.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_phase_step[31:0]
//   rsp      out        rsp_valid/rsp_stall   rsp_sample[15:0] signed
//   csr      in         APB, pready tied high mod_ratio @0x0, mod_depth @0x4
//
// One request per cycle sustained unless a stall on rsp fills the queue; each request yields one sample.
// Latency is set by the modulator ROM read, the depth multiply, the phase add and the
// carrier ROM read; both lookups share one dual-port quarter-wave ROM.
// Reset clears the phase accumulators, the queue and all valid flags; the ROM is constant.
// A stall on rsp freezes the back end; the four-entry queue then fills before req stalls.
module two_operator_fm_oscillator #(
   parameter int TABLE_ADDR_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fmo_pkg::PHASE_W-1:0]         req_phase_step,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fmo_pkg::SAMPLE_W-1:0] rsp_sample,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import fmo_pkg::*;

   logic               csr_write;
   csr_index_type      csr_index;
   logic [RATIO_W-1:0] mod_ratio_ff, mod_ratio_in;
   logic [DEPTH_W-1:0] mod_depth_ff, mod_depth_in;

   logic               push, q_full, pop, head_valid;
   fmo_item_type       push_item, head_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      mod_ratio_in = mod_ratio_ff;
      mod_depth_in = mod_depth_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MOD_RATIO: mod_ratio_in = csr_pwdata[RATIO_W-1:0];
            CSR_MOD_DEPTH: mod_depth_in = csr_pwdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_MOD_RATIO: csr_prdata = {{(32-RATIO_W){1'b0}}, mod_ratio_ff};
         CSR_MOD_DEPTH: csr_prdata = {{(32-DEPTH_W){1'b0}}, mod_depth_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ratio_ff <= RATIO_W'(205887);
         mod_depth_ff <= DEPTH_W'(136713055);
      end else begin
         mod_ratio_ff <= mod_ratio_in;
         mod_depth_ff <= mod_depth_in;
      end
   end

   fmo_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_phase_step (req_phase_step),
      .mod_ratio      (mod_ratio_ff),
      .q_full         (q_full),
      .push           (push),
      .push_item      (push_item)
   );

   fmo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   fmo_back #(.ADDR_BITS(TABLE_ADDR_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .mod_depth  (mod_depth_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample)
   );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the two-operator FM oscillator: phases, config sweeps, stalls.
module tb_top;
   import fmo_pkg::*;

   localparam int TABLE_BITS  = 12;
   localparam int WAVE_SIZE   = 1 << TABLE_BITS;
   localparam int STALL_LIMIT = 2000;
   localparam int SHOW_LIMIT  = 10;
   localparam int BLOCKS      = 4;
   localparam int BLOCK_STEPS = 65;

   // Phase-accumulator pair, sine ROM and the samples still owed by the block.
   class fm_voice_model_type;
      logic signed [SAMPLE_W-1:0] wave [WAVE_SIZE];
      logic signed [SAMPLE_W-1:0] pending_samples [$];
      bit [PHASE_W-1:0] carrier_acc;
      bit [PHASE_W-1:0] modulator_acc;
      bit [RATIO_W-1:0] ratio;
      bit [DEPTH_W-1:0] depth;
      int bad_count;

      function new();
         carrier_acc   = '0;
         modulator_acc = '0;
         ratio         = RATIO_W'(205887);
         depth         = DEPTH_W'(136713055);
         bad_count     = 0;
         build_wave();
      endfunction

      // floor(a * b / 2^60)
      function bit [63:0] q60_mul(bit [63:0] a, bit [63:0] b);
         bit [127:0] prod;
         prod = {64'd0, a} * {64'd0, b};
         return prod[123:60];
      endfunction

      function bit [63:0] arctan_recip(bit [63:0] x);
         bit [63:0] x2;
         bit [63:0] term;
         bit [63:0] sum;
         x2   = x * x;
         term = (64'd1 << 60) / x;
         sum  = term;
         for (int n = 1; n < 64; n++) begin
            term = term / x2;
            if (term == 0) break;
            if (n % 2 == 1) sum = sum - term / 64'(2 * n + 1);
            else sum = sum + term / 64'(2 * n + 1);
         end
         return sum;
      endfunction

      function bit [63:0] sine_q60(bit [63:0] x);
         bit [63:0] sum;
         bit [63:0] term;
         sum  = x;
         term = x;
         for (int n = 1; n < 40; n++) begin
            term = q60_mul(q60_mul(term, x), x) / 64'((2 * n) * (2 * n + 1));
            if (term == 0) break;
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         return sum;
      endfunction

      // Fill one quarter wave, then mirror and negate it.
      function void build_wave();
         bit [63:0] pi_q;
         bit [63:0] step_hi;
         bit [63:0] step_lo;
         bit [63:0] theta;
         bit [63:0] mag;
         int quarter;
         logic signed [SAMPLE_W-1:0] qtr [WAVE_SIZE/4+1];
         pi_q    = 64'd16 * arctan_recip(64'd5) - 64'd4 * arctan_recip(64'd239);
         quarter = WAVE_SIZE / 4;
         step_hi = pi_q >> (TABLE_BITS - 1);
         step_lo = pi_q & ((64'd1 << (TABLE_BITS - 1)) - 64'd1);
         for (int k = 0; k <= quarter; k++) begin
            theta = step_hi * 64'(k) + ((step_lo * 64'(k)) >> (TABLE_BITS - 1));
            mag   = q60_mul(sine_q60(theta), 64'd32767);
            if (k == 0) qtr[k] = '0;
            else if (k == quarter) qtr[k] = 16'sd32767;
            else qtr[k] = mag[SAMPLE_W-1:0];
         end
         for (int i = 0; i < WAVE_SIZE; i++) begin
            if (i <= quarter) wave[i] = qtr[i];
            else if (i <= 2 * quarter) wave[i] = qtr[2 * quarter - i];
            else if (i <= 3 * quarter) wave[i] = -qtr[i - 2 * quarter];
            else wave[i] = -qtr[WAVE_SIZE - i];
         end
      endfunction

      function void write_register(csr_index_type idx, bit [31:0] value);
         case (idx)
            CSR_MOD_RATIO: ratio = value[RATIO_W-1:0];
            CSR_MOD_DEPTH: depth = value[DEPTH_W-1:0];
            default: ;
         endcase
      endfunction

      function bit [31:0] register_value(csr_index_type idx);
         return (idx == CSR_MOD_RATIO) ? 32'(ratio) : 32'(depth);
      endfunction

      function void flag(string what);
         bad_count++;
         if (bad_count <= SHOW_LIMIT) $display("%0t: %s", $time, what);
      endfunction

      function void take_step(bit [PHASE_W-1:0] step);
         logic signed [SAMPLE_W-1:0] mod_val;
         longint offset;
         bit [PHASE_W-1:0] lookup;
         bit [63:0] mod_inc;
         mod_val = wave[modulator_acc >> (PHASE_W - TABLE_BITS)];
         offset  = (longint'(depth) * longint'(mod_val)) / longint'(32768);
         lookup  = carrier_acc + offset[31:0];
         pending_samples.push_back(wave[lookup >> (PHASE_W - TABLE_BITS)]);
         carrier_acc   = carrier_acc + step;
         mod_inc       = 64'(step) * 64'(ratio);
         modulator_acc = modulator_acc + mod_inc[47:16];
      endfunction

      function void match_sample(logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (pending_samples.size() == 0) begin
            flag($sformatf("unexpected sample %0d", got));
            return;
         end
         want = pending_samples.pop_front();
         if (got !== want) flag($sformatf("sample mismatch: expected %0d, got %0d", want, got));
      endfunction
   endclass

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [PHASE_W-1:0]         req_phase_step = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       csr_psel       = 1'b0;
   logic                       csr_penable    = 1'b0;
   logic                       csr_pwrite     = 1'b0;
   logic [2:0]                 csr_paddr      = '0;
   logic [31:0]                csr_pwdata     = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   fm_voice_model_type model = new();

   two_operator_fm_oscillator #(.TABLE_ADDR_BITS(TABLE_BITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_phase_step (req_phase_step),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample     (rsp_sample),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) model.take_step(req_phase_step);
         if (rsp_valid && !rsp_stall) model.match_sample(rsp_sample);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Hold the request until it is taken; idle first at the current rate.
   task automatic push_step(input logic [PHASE_W-1:0] step);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_phase_step <= step;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait for every owed sample, then for the pipeline to settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (model.pending_samples.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input csr_index_type idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= 3'(idx * 4);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_register(input csr_index_type idx);
      logic [31:0] back;
      csr_access(1'b0, idx, '0, back);
      if (back !== model.register_value(idx))
         model.flag($sformatf("register %s reads 0x%08h, expected 0x%08h",
                              idx.name(), back, model.register_value(idx)));
   endtask

   task automatic configure(input logic [31:0] ratio_word, input logic [31:0] depth_word);
      logic [31:0] unused;
      drain();
      csr_access(1'b1, CSR_MOD_RATIO, ratio_word, unused);
      model.write_register(CSR_MOD_RATIO, ratio_word);
      verify_register(CSR_MOD_RATIO);
      csr_access(1'b1, CSR_MOD_DEPTH, depth_word, unused);
      model.write_register(CSR_MOD_DEPTH, depth_word);
      verify_register(CSR_MOD_DEPTH);
   endtask

   function automatic logic [31:0] pick_ratio();
      case ($urandom_range(4))
         0: return $urandom();
         1: return $urandom_range(32'h0004_0000, 32'h0000_8000);
         2: return 32'h0001_0000;
         3: return $urandom_range(1) ? 32'h00FF_FFFF : 32'h0;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic logic [31:0] pick_depth();
      case ($urandom_range(4))
         0: return $urandom();
         1: return $urandom_range(32'h0800_0000);
         2: return 32'h0;
         3: return 32'h7FFF_FFFF;
         default: return $urandom_range(65535);
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(9))
         6, 7: return $urandom();
         8: begin
            case ($urandom_range(3))
               0: return 32'h0;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         9: return 32'd1 << $urandom_range(31);
         default: return $urandom_range(32'h0400_0000);
      endcase
   endfunction

   initial begin
      logic [31:0] opening [8];
      opening = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'h1,
                  32'h0123_4567, 32'h7FFF_FFFF};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_register(CSR_MOD_RATIO);
      verify_register(CSR_MOD_DEPTH);

      // directed: reset settings, then both registers at their top, then at zero
      send_gap_pct  = 35;
      rsp_stall_pct = 69;
      foreach (opening[i]) push_step(opening[i]);
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (4) push_step(32'hFFFF_FFFF);
      push_step(32'h0100_0000);
      push_step(32'h0AAA_AAAA);
      repeat (3) push_step($urandom());
      configure(32'h0, 32'h0);
      repeat (3) push_step($urandom());

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct  = (phase == 0) ? 35 : (phase == 1) ? 69 : 0;
         rsp_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 35 : 0;
         for (int blk = 0; blk < BLOCKS; blk++) begin
            configure(pick_ratio(), pick_depth());
            repeat (BLOCK_STEPS) push_step(pick_step());
         end
      end
      drain();

      if (model.bad_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
design/fmo_pkg.sv
design/fmo_front.sv
design/fmo_queue.sv
design/fmo_rom.sv
design/fmo_back.sv
design/two_operator_fm_oscillator.sv
tb/sv/tb_top.sv
